>>> rtl/drrip_stream_aware_replacement_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the DRRIP replacement engine
// Property wrappers used by the checker in drrip_chk.sv.
// ----------------------------------------------------------------------------
`ifndef DRRIP_STREAM_AWARE_REPLACEMENT_DEFINES_SVH
`define DRRIP_STREAM_AWARE_REPLACEMENT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define DRRIP_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drrip check failed");

// next-cycle implication, disabled while in reset
`define DRRIP_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drrip check failed");

`endif

>>> rtl/drrip_pkg.sv
// ----------------------------------------------------------------------------
// drrip_pkg
// Shared constants and types of the DRRIP replacement engine.
// ----------------------------------------------------------------------------
package drrip_pkg;

	localparam int NUM_SETS  = 2048;
	localparam int NUM_WAYS  = 16;
	localparam int SEL_W     = 10;
	localparam int SET_W     = $clog2(NUM_SETS);
	localparam int WAY_W     = 4;
	localparam int ADDR_W    = 48;
	localparam int STRIDE_W  = 13;
	localparam int LEAD_W    = 11;
	localparam int CFG_IDX_W = 2;
	localparam int MASK_W    = 16;
	localparam int CHANCE_W  = 5;

	localparam logic [SEL_W-1:0] SEL_MAX = {SEL_W{1'b1}};
	localparam logic [SEL_W-1:0] SEL_MID = SEL_MAX >> 1;

	localparam logic [STRIDE_W-1:0] STRIDE_RST  = STRIDE_W'(64);
	localparam logic [LEAD_W-1:0]   LEADERS_RST = LEAD_W'(32);

	localparam logic [1:0] RRPV_DISTANT = 2'd3;
	localparam logic [1:0] RRPV_LONG    = 2'd2;
	localparam logic [1:0] RRPV_NEAR    = 2'd0;
	localparam logic [1:0] STRM_SAT     = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_LEADERS = CFG_IDX_W'(1);

	// operation and answer codes
	localparam logic OP_VICTIM  = 1'b0;
	localparam logic OP_UPDATE  = 1'b1;
	localparam logic ANS_VICTIM = 1'b0;
	localparam logic ANS_UPDATE = 1'b1;

	typedef logic [NUM_WAYS-1:0][1:0] rrpv_row_t;

	typedef struct packed {
		logic [1:0]        cnt;
		logic [ADDR_W-1:0] prev;
	} strm_ent_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_CALC  = 3'b100
	} state_t;

endpackage

>>> rtl/drrip_stream_aware_replacement.sv
// ----------------------------------------------------------------------------
// drrip_stream_aware_replacement
// DRRIP replacement engine with 2-bit RRPVs and per-set stream detection.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. Its single result
// appears on victim_way/answer_kind with done high for one cycle, raised by a
// register after the CALC state, and is taken at the edge that ends that cycle;
// the result cannot be held off. busy is high in the CALC state in between and
// is low again while done is shown, so a new transaction can be taken while a
// result is shown. The CALC state comes from the read-modify-write of one set
// row in the single-port RRPV and stream memories: read on accept, modify and
// write back in the next cycle. After reset busy stays high for a clearing pass
// over all 2048 sets (one set a cycle) while the memories are initialised;
// configuration writes are taken at all times.
// ----------------------------------------------------------------------------
module drrip_stream_aware_replacement (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic                                 op,
	input  logic [drrip_pkg::SET_W-1:0]          set_index,
	input  logic [drrip_pkg::WAY_W-1:0]          way_index,
	input  logic                                 was_hit,
	input  logic [drrip_pkg::ADDR_W-1:0]         phys_address,
	input  logic [drrip_pkg::MASK_W-1:0]         invalid_ways,
	input  logic [drrip_pkg::CHANCE_W-1:0]       chance,
	output logic                                 done,
	output logic [drrip_pkg::WAY_W-1:0]          victim_way,
	output logic                                 answer_kind,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [drrip_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drrip_pkg::STRIDE_W-1:0]       cfg_data
);

	drrip_pkg::state_t                    state_q, state_d;
	logic [drrip_pkg::SET_W-1:0]          clr_q;
	logic [drrip_pkg::STRIDE_W-1:0]       stride_q;
	logic [drrip_pkg::LEAD_W-1:0]         leaders_q;
	logic [drrip_pkg::SEL_W-1:0]          sel_q, sel_d;
	logic                                 done_q;
	logic [drrip_pkg::WAY_W-1:0]          victim_q, victim_d;
	logic                                 kind_q;

	// captured transaction
	logic                                 op_s1;
	logic [drrip_pkg::SET_W-1:0]          set_s1;
	logic [drrip_pkg::WAY_W-1:0]          way_s1;
	logic                                 hit_s1;
	logic [drrip_pkg::ADDR_W-1:0]         addr_s1;
	logic [drrip_pkg::MASK_W-1:0]         inval_s1;
	logic [drrip_pkg::CHANCE_W-1:0]       chance_s1;

	// memories
	drrip_pkg::rrpv_row_t                 rrpv_mem [drrip_pkg::NUM_SETS];
	drrip_pkg::strm_ent_t                 strm_mem [drrip_pkg::NUM_SETS];
	drrip_pkg::rrpv_row_t                 rrpv_rd_s1, rrpv_wd;
	drrip_pkg::strm_ent_t                 strm_rd_s1, strm_wd;
	logic                                 rrpv_we, strm_we;
	logic [drrip_pkg::SET_W-1:0]          mem_wa;

	logic                                 accept;

	// victim path
	logic                                 inv_any;
	logic [drrip_pkg::WAY_W-1:0]          first_inv, first_far;
	logic                                 has3, has2, has1;
	logic [1:0]                           age_add;
	drrip_pkg::rrpv_row_t                 aged_row, upd_row;

	// update path
	logic [drrip_pkg::ADDR_W-1:0]         delta, stride_w, stride_neg;
	logic                                 stride_hit;
	logic [1:0]                           cnt_new;
	logic                                 is_srrip_lead, is_brrip_lead;
	logic [1:0]                           brrip_ins, ins_val;
	logic                                 way_ok;

	assign accept    = start && !busy;
	assign busy      = (state_q != drrip_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done        = done_q;
	assign victim_way  = victim_q;
	assign answer_kind = kind_q;

	// ---------------- victim selection ----------------
	always_comb begin
		inv_any   = |inval_s1;
		first_inv = '0;
		for (int w = drrip_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (w < drrip_pkg::MASK_W && inval_s1[w])
				first_inv = drrip_pkg::WAY_W'(w);
		end
		has3 = 1'b0;
		has2 = 1'b0;
		has1 = 1'b0;
		for (int w = 0; w < drrip_pkg::NUM_WAYS; w++) begin
			has3 = has3 | (rrpv_rd_s1[w] == 2'd3);
			has2 = has2 | (rrpv_rd_s1[w] == 2'd2);
			has1 = has1 | (rrpv_rd_s1[w] == 2'd1);
		end
		// age by the distance of the oldest way from distant
		if (has3)      age_add = 2'd0;
		else if (has2) age_add = 2'd1;
		else if (has1) age_add = 2'd2;
		else           age_add = 2'd3;
		for (int w = 0; w < drrip_pkg::NUM_WAYS; w++)
			aged_row[w] = rrpv_rd_s1[w] + age_add;
		first_far = '0;
		for (int w = drrip_pkg::NUM_WAYS - 1; w >= 0; w--) begin
			if (aged_row[w] == drrip_pkg::RRPV_DISTANT)
				first_far = drrip_pkg::WAY_W'(w);
		end
	end

	// ---------------- update path ----------------
	always_comb begin
		delta      = (strm_rd_s1.prev != '0) ? (addr_s1 - strm_rd_s1.prev) : '0;
		stride_w   = drrip_pkg::ADDR_W'(stride_q);
		stride_neg = '0 - stride_w;
		stride_hit = (stride_q != '0) && ((delta == stride_w) || (delta == stride_neg));
		if (stride_hit)
			cnt_new = (strm_rd_s1.cnt != drrip_pkg::STRM_SAT) ?
				strm_rd_s1.cnt + 2'd1 : strm_rd_s1.cnt;
		else
			cnt_new = (strm_rd_s1.cnt != 2'd0) ? strm_rd_s1.cnt - 2'd1 : strm_rd_s1.cnt;

		is_srrip_lead = {1'b0, set_s1} < {1'b0, leaders_q};
		is_brrip_lead = !is_srrip_lead && ({1'b0, set_s1} < {leaders_q, 1'b0});

		brrip_ins = (chance_s1 == '0) ? drrip_pkg::RRPV_LONG : drrip_pkg::RRPV_DISTANT;
		if (is_srrip_lead)
			ins_val = drrip_pkg::RRPV_LONG;
		else if (is_brrip_lead)
			ins_val = brrip_ins;
		else
			ins_val = (sel_q >= drrip_pkg::SEL_MID) ? drrip_pkg::RRPV_LONG : brrip_ins;
		if (cnt_new == drrip_pkg::STRM_SAT)
			ins_val = drrip_pkg::RRPV_DISTANT;

		way_ok  = ({1'b0, way_s1} < (drrip_pkg::WAY_W + 1)'(drrip_pkg::NUM_WAYS));
		upd_row = rrpv_rd_s1;
		upd_row[way_s1] = hit_s1 ? drrip_pkg::RRPV_NEAR : ins_val;

		// dueling selector trains on leader fills only
		sel_d = sel_q;
		if (!hit_s1) begin
			if (is_srrip_lead && sel_q != '0)
				sel_d = sel_q - 1'b1;
			else if (is_brrip_lead && sel_q != drrip_pkg::SEL_MAX)
				sel_d = sel_q + 1'b1;
		end
	end

	// ---------------- memory write control ----------------
	always_comb begin
		rrpv_we  = 1'b0;
		strm_we  = 1'b0;
		mem_wa   = set_s1;
		rrpv_wd  = aged_row;
		strm_wd  = '{cnt: cnt_new, prev: addr_s1};
		victim_d = drrip_pkg::WAY_W'(0);
		state_d  = state_q;
		unique case (state_q)
			drrip_pkg::ST_CLEAR: begin
				rrpv_we = 1'b1;
				strm_we = 1'b1;
				mem_wa  = clr_q;
				rrpv_wd = {drrip_pkg::NUM_WAYS{drrip_pkg::RRPV_DISTANT}};
				strm_wd = '0;
				if (clr_q == drrip_pkg::SET_W'(drrip_pkg::NUM_SETS - 1))
					state_d = drrip_pkg::ST_IDLE;
			end
			drrip_pkg::ST_IDLE: begin
				if (accept)
					state_d = drrip_pkg::ST_CALC;
			end
			drrip_pkg::ST_CALC: begin
				state_d = drrip_pkg::ST_IDLE;
				if (op_s1 == drrip_pkg::OP_VICTIM) begin
					rrpv_we  = !inv_any;
					victim_d = inv_any ? first_inv : first_far;
				end else begin
					rrpv_we = way_ok;
					rrpv_wd = upd_row;
					strm_we = 1'b1;
				end
			end
			default: state_d = drrip_pkg::ST_CLEAR;
		endcase
	end

	// set rows: read on accept, written back in the cycle after
	always_ff @(posedge clk) begin
		if (rrpv_we)
			rrpv_mem[mem_wa] <= rrpv_wd;
		if (accept)
			rrpv_rd_s1 <= rrpv_mem[set_index];
	end

	always_ff @(posedge clk) begin
		if (strm_we)
			strm_mem[mem_wa] <= strm_wd;
		if (accept)
			strm_rd_s1 <= strm_mem[set_index];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			set_s1    <= set_index;
			way_s1    <= way_index;
			hit_s1    <= was_hit;
			addr_s1   <= phys_address;
			inval_s1  <= invalid_ways;
			chance_s1 <= chance;
		end
		if (state_q == drrip_pkg::ST_CALC)
			victim_q <= victim_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= drrip_pkg::ST_CLEAR;
			clr_q     <= '0;
			sel_q     <= drrip_pkg::SEL_MID;
			done_q    <= 1'b0;
			kind_q    <= drrip_pkg::ANS_VICTIM;
			stride_q  <= drrip_pkg::STRIDE_RST;
			leaders_q <= drrip_pkg::LEADERS_RST;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == drrip_pkg::ST_CALC);
			if (state_q == drrip_pkg::ST_CLEAR)
				clr_q <= clr_q + 1'b1;
			if (state_q == drrip_pkg::ST_CALC) begin
				kind_q <= (op_s1 == drrip_pkg::OP_VICTIM) ?
					drrip_pkg::ANS_VICTIM : drrip_pkg::ANS_UPDATE;
				if (op_s1 == drrip_pkg::OP_UPDATE)
					sel_q <= sel_d;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					drrip_pkg::CFG_STRIDE:  stride_q  <= cfg_data;
					drrip_pkg::CFG_LEADERS: leaders_q <= cfg_data[drrip_pkg::LEAD_W-1:0];
					default: ;
				endcase
			end
		end
	end

endmodule

>>> rtl/drrip_chk.sv
// ----------------------------------------------------------------------------
// drrip_chk
// Port-level timing checks for the DRRIP replacement engine.
// ----------------------------------------------------------------------------
`include "drrip_stream_aware_replacement_defines.svh"

module drrip_chk (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic                             busy,
	input  logic                             done,
	input  logic [drrip_pkg::WAY_W-1:0]      victim_way,
	input  logic                             answer_kind
);

	// every accepted transaction is followed by its result on done
	`DRRIP_ASSERT_NOW(a_result_lat, start && !busy, ##2 done)
	// engine is occupied in the cycle after an accept
	`DRRIP_ASSERT_NEXT(a_busy_after, start && !busy, busy && !done)
	// the next transaction can be taken while a result is shown
	`DRRIP_ASSERT_NOW(a_free_on_done, done, !busy)
	// update acknowledgements carry way 0
	`DRRIP_ASSERT_NOW(a_upd_way0, done && answer_kind == drrip_pkg::ANS_UPDATE,
		victim_way == '0)

endmodule

bind drrip_stream_aware_replacement drrip_chk u_drrip_chk (.*);

>>> verif/rrip_shadow_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Shadow state of the DRRIP replacement engine
// Holds its own RRPV, stream and selector state, predicts the answer to each
// accepted transaction and checks the answers the block returns, in order.
// ----------------------------------------------------------------------------
package rrip_shadow_pkg;

	import drrip_pkg::*;

	typedef struct packed {
		logic                op;
		logic [SET_W-1:0]    set_idx;
		logic [WAY_W-1:0]    way;
		logic                hit;
		logic [ADDR_W-1:0]   addr;
		logic [MASK_W-1:0]   inval;
		logic [CHANCE_W-1:0] chance;
	} access_t;

	typedef struct packed {
		logic [WAY_W-1:0] way;
		logic             kind;
	} answer_t;

	typedef enum logic [1:0] {
		SET_FOLLOWER,
		SET_SRRIP_LEAD,
		SET_BRRIP_LEAD
	} set_role_t;

	class rrip_shadow;
		logic [1:0]          rrpv [NUM_SETS][NUM_WAYS];
		logic [1:0]          stream_cnt [NUM_SETS];
		logic [ADDR_W-1:0]   prev_addr [NUM_SETS];
		logic [SEL_W-1:0]    selector;
		logic [STRIDE_W-1:0] stride;
		logic [LEAD_W-1:0]   leaders;
		answer_t             pending_answers [$];
		int                  errors;
		int                  n_victims;
		int                  n_aged;
		int                  n_updates;
		int                  n_streamed;
		int                  n_writes;

		function new();
			for (int s = 0; s < NUM_SETS; s++) begin
				for (int w = 0; w < NUM_WAYS; w++)
					rrpv[s][w] = RRPV_DISTANT;
				stream_cnt[s] = '0;
				prev_addr[s]  = '0;
			end
			selector   = SEL_MID;
			stride     = STRIDE_RST;
			leaders    = LEADERS_RST;
			errors     = 0;
			n_victims  = 0;
			n_aged     = 0;
			n_updates  = 0;
			n_streamed = 0;
			n_writes   = 0;
		endfunction

		function void flag(string msg);
			errors++;
			$display("%0t: %s", $time, msg);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [STRIDE_W-1:0] data);
			n_writes++;
			case (idx)
				CFG_STRIDE:  stride = data;
				CFG_LEADERS: leaders = data[LEAD_W-1:0];
				default: ;
			endcase
		endfunction

		function set_role_t role_of(int s);
			if (s < int'(leaders))
				return SET_SRRIP_LEAD;
			if (s < 2 * int'(leaders))
				return SET_BRRIP_LEAD;
			return SET_FOLLOWER;
		endfunction

		// stimulus peeks here to fill the way a victim request would name
		function int first_distant_way(int s);
			for (int w = 0; w < NUM_WAYS; w++)
				if (rrpv[s][w] == RRPV_DISTANT)
					return w;
			return -1;
		endfunction

		function logic [WAY_W-1:0] choose_victim(int s, logic [MASK_W-1:0] inval);
			logic [1:0] top;
			logic [1:0] lift;
			top = RRPV_NEAR;
			for (int w = 0; w < NUM_WAYS && w < MASK_W; w++)
				if (inval[w])
					return WAY_W'(w);
			for (int w = 0; w < NUM_WAYS; w++)
				if (rrpv[s][w] > top)
					top = rrpv[s][w];
			// age the whole set in one go; the aged values stay
			if (top != RRPV_DISTANT) begin
				n_aged++;
				lift = RRPV_DISTANT - top;
				for (int w = 0; w < NUM_WAYS; w++)
					rrpv[s][w] = rrpv[s][w] + lift;
			end
			for (int w = 0; w < NUM_WAYS; w++)
				if (rrpv[s][w] == RRPV_DISTANT)
					return WAY_W'(w);
			return '0;
		endfunction

		function void apply_update(int s, access_t a);
			logic [ADDR_W-1:0] delta;
			logic [ADDR_W-1:0] step;
			logic [1:0]        bimodal;
			logic [1:0]        ins;
			set_role_t         role;
			role  = role_of(s);
			step  = ADDR_W'(stride);
			// an empty previous address counts as no movement
			delta = (prev_addr[s] != '0) ? a.addr - prev_addr[s] : '0;
			prev_addr[s] = a.addr;
			if (stride != '0 && (delta == step || delta == ADDR_W'(0) - step)) begin
				if (stream_cnt[s] != STRM_SAT)
					stream_cnt[s]++;
			end else if (stream_cnt[s] != 2'd0) begin
				stream_cnt[s]--;
			end
			if (a.hit) begin
				if (int'(a.way) < NUM_WAYS)
					rrpv[s][a.way] = RRPV_NEAR;
				return;
			end
			bimodal = (a.chance == '0) ? RRPV_LONG : RRPV_DISTANT;
			case (role)
				SET_SRRIP_LEAD: ins = RRPV_LONG;
				SET_BRRIP_LEAD: ins = bimodal;
				default:        ins = (selector >= SEL_MID) ? RRPV_LONG : bimodal;
			endcase
			if (stream_cnt[s] == STRM_SAT) begin
				ins = RRPV_DISTANT;
				n_streamed++;
			end
			if (int'(a.way) < NUM_WAYS)
				rrpv[s][a.way] = ins;
			if (role == SET_SRRIP_LEAD && selector != '0)
				selector--;
			else if (role == SET_BRRIP_LEAD && selector != SEL_MAX)
				selector++;
		endfunction

		function void note_access(access_t a);
			answer_t ans;
			int      s;
			s = int'(a.set_idx) % NUM_SETS;
			if (a.op == OP_VICTIM) begin
				n_victims++;
				ans.way  = choose_victim(s, a.inval);
				ans.kind = ANS_VICTIM;
			end else begin
				n_updates++;
				apply_update(s, a);
				ans.way  = '0;
				ans.kind = ANS_UPDATE;
			end
			pending_answers.push_back(ans);
		endfunction

		function void check_answer(logic [WAY_W-1:0] way, logic kind);
			answer_t exp;
			if (pending_answers.size() == 0) begin
				flag($sformatf("answer with nothing outstanding: victim_way %0d answer_kind %0d",
					way, kind));
				return;
			end
			exp = pending_answers.pop_front();
			if (way !== exp.way)
				flag($sformatf("victim_way expected %0d, got %0d", exp.way, way));
			if (kind !== exp.kind)
				flag($sformatf("answer_kind expected %0d, got %0d", exp.kind, kind));
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction
	endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives victim requests and access updates into the replacement engine in
// bursts, across several stride and leader settings, and checks every answer
// against the shadow state in rrip_shadow_pkg.
// ----------------------------------------------------------------------------
module tb_top;

	import drrip_pkg::*;
	import rrip_shadow_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);
	localparam int WATCHDOG_LIMIT = 10000;
	localparam int HOT_SETS       = 3;
	localparam int PHASES         = 5;
	localparam int ITEMS_PER_PHASE = 120;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                op;
	logic [SET_W-1:0]    set_index;
	logic [WAY_W-1:0]    way_index;
	logic                was_hit;
	logic [ADDR_W-1:0]   phys_address;
	logic [MASK_W-1:0]   invalid_ways;
	logic [CHANCE_W-1:0] chance;
	logic                done;
	logic [WAY_W-1:0]    victim_way;
	logic                answer_kind;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [STRIDE_W-1:0] cfg_data;

	rrip_shadow          shadow;
	int                  idle_cycles;
	int                  burst_left;
	int                  cur_stride;
	int                  cur_leaders;
	int                  hot_sets [HOT_SETS];
	bit [ADDR_W-1:0]     stim_addr [NUM_SETS];
	int                  stride_plan [PHASES] = '{1, 4096, 0, 8191, 192};
	int                  leader_plan [PHASES] = '{0, 'h1C00, 2047, 1, 300};

	drrip_stream_aware_replacement dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.op           (op),
		.set_index    (set_index),
		.way_index    (way_index),
		.was_hit      (was_hit),
		.phys_address (phys_address),
		.invalid_ways (invalid_ways),
		.chance       (chance),
		.done         (done),
		.victim_way   (victim_way),
		.answer_kind  (answer_kind),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				shadow.check_answer(victim_way, answer_kind);
			if (start && !busy)
				shadow.note_access('{op, set_index, way_index, was_hit, phys_address,
					invalid_ways, chance});
			if (cfg_valid && cfg_ready)
				shadow.write_reg(cfg_index, cfg_data);
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired, %0d answers outstanding", $time,
					shadow.pending());
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic access_t victim_req(int s, logic [MASK_W-1:0] inval);
		access_t a;
		a         = '0;
		a.op      = OP_VICTIM;
		a.set_idx = SET_W'(s);
		a.inval   = inval;
		return a;
	endfunction

	function automatic access_t update_req(int s, int w, logic hit, logic [ADDR_W-1:0] addr,
		int draw);
		access_t a;
		a         = '0;
		a.op      = OP_UPDATE;
		a.set_idx = SET_W'(s);
		a.way     = WAY_W'(w);
		a.hit     = hit;
		a.addr    = addr;
		a.chance  = CHANCE_W'(draw);
		return a;
	endfunction

	// hot sets mostly sit on the leader boundaries of the current setting, else anywhere
	function automatic void choose_hot_sets();
		int v;
		for (int i = 0; i < HOT_SETS; i++) begin
			case ($urandom_range(0, 4))
				0:       v = cur_leaders - 1;
				1:       v = cur_leaders;
				2:       v = 2 * cur_leaders - 1;
				3:       v = 2 * cur_leaders;
				default: v = $urandom_range(0, NUM_SETS - 1);
			endcase
			if (v < 0)
				v = 0;
			if (v >= NUM_SETS)
				v = NUM_SETS - 1;
			hot_sets[i] = v;
		end
	endfunction

	function automatic access_t make_access();
		access_t a;
		int      s;
		int      w;
		int      pick;
		s = ($urandom_range(0, 99) < 90) ? hot_sets[$urandom_range(0, HOT_SETS - 1)]
			: $urandom_range(0, NUM_SETS - 1);
		// unused fields carry noise too
		a.set_idx = SET_W'(s);
		a.op      = ($urandom_range(0, 99) < 40) ? OP_VICTIM : OP_UPDATE;
		a.way     = WAY_W'($urandom_range(0, NUM_WAYS - 1));
		a.hit     = 1'($urandom);
		a.addr    = rand_addr();
		a.inval   = MASK_W'($urandom);
		a.chance  = ($urandom_range(0, 3) == 0) ? '0 : CHANCE_W'($urandom);
		if (a.op == OP_VICTIM) begin
			case ($urandom_range(0, 9))
				0, 1:    a.inval = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
				2:       a.inval = MASK_W'($urandom) & MASK_W'($urandom);
				default: a.inval = '0;
			endcase
			return a;
		end
		a.hit = ($urandom_range(0, 99) < 35);
		if (!a.hit) begin
			// fill where the victim search would land, as a cache would
			w = shadow.first_distant_way(s);
			if (w >= 0 && $urandom_range(0, 9) != 0)
				a.way = WAY_W'(w);
		end
		pick = $urandom_range(0, 9);
		if (pick < 3)
			a.addr = stim_addr[s] + ADDR_W'(cur_stride);
		else if (pick < 6)
			a.addr = stim_addr[s] - ADDR_W'(cur_stride);
		else if (pick == 8)
			a.addr = stim_addr[s] + ADDR_W'($urandom_range(1, 256));
		else if (pick == 9)
			a.addr = '0;
		stim_addr[s] = a.addr;
		return a;
	endfunction

	task automatic issue(input access_t a);
		if (burst_left == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		op           = a.op;
		set_index    = a.set_idx;
		way_index    = a.way;
		was_hit      = a.hit;
		phys_address = a.addr;
		invalid_ways = a.inval;
		chance       = a.chance;
		start        = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic drain();
		start = 1'b0;
		while (shadow.pending() != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = STRIDE_W'(data);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		op           = OP_VICTIM;
		set_index    = '0;
		way_index    = '0;
		was_hit      = 1'b0;
		phys_address = '0;
		invalid_ways = '0;
		chance       = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		idle_cycles  = 0;
		burst_left   = 0;
		cur_stride   = 64;
		cur_leaders  = 32;
		shadow       = new();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		// clearing pass after reset
		while (busy)
			@(negedge clk);

		// writes to unmapped indexes must leave both registers alone
		program_reg(CFG_SPARE_LO, 'h1FFF);
		program_reg(CFG_SPARE_HI, 'h0AAA);

		// directed: default stride 64, 32 leaders per policy
		issue(victim_req(0, 16'h0000));
		issue(victim_req(NUM_SETS - 1, 16'h8000));
		issue(victim_req(NUM_SETS - 1, 16'hFFFF));
		issue(update_req(NUM_SETS - 1, 15, 1'b1, 48'hFFFF_FFFF_FFFF, 31));
		// wraps past the top of the address space: +stride, then -stride
		issue(update_req(NUM_SETS - 1, 14, 1'b0, 48'h0000_0000_003F, 0));
		issue(update_req(NUM_SETS - 1, 13, 1'b0, 48'hFFFF_FFFF_FFFF, 0));
		// BRRIP leader: bimodal long insert, then a stream saturates the counter
		issue(update_req(40, 3, 1'b0, 48'h1000, 0));
		issue(update_req(40, 4, 1'b0, 48'h1040, 5));
		issue(update_req(40, 5, 1'b0, 48'h1000, 7));
		issue(update_req(40, 6, 1'b0, 48'h1040, 0));
		issue(update_req(40, 7, 1'b1, 48'h1080, 0));
		issue(update_req(40, 8, 1'b0, 48'h5000, 1));
		issue(victim_req(40, 16'h0000));
		// SRRIP leader fill and hit
		issue(update_req(1, 0, 1'b0, 48'h40, 0));
		issue(victim_req(1, 16'h0000));
		issue(update_req(1, 0, 1'b1, 48'h80, 9));
		issue(victim_req(1, 16'h0001));
		issue(victim_req(NUM_SETS - 1, 16'h0000));
		issue(update_req(100, 2, 1'b0, 48'h0, 0));
		issue(victim_req(100, 16'h4000));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			program_reg(CFG_STRIDE, stride_plan[p]);
			program_reg(CFG_LEADERS, leader_plan[p]);
			cur_stride  = stride_plan[p] & ((1 << STRIDE_W) - 1);
			cur_leaders = leader_plan[p] & ((1 << LEAD_W) - 1);
			choose_hot_sets();
			repeat (ITEMS_PER_PHASE)
				issue(make_access());
			drain();
		end
		repeat (4) @(posedge clk);

		$display("Covered %0d victim requests (%0d aged a set) and %0d updates (%0d streaming inserts)",
			shadow.n_victims, shadow.n_aged, shadow.n_updates, shadow.n_streamed);
		$display("%0d register writes across %0d stride/leader settings, selector ended at %0d",
			shadow.n_writes, PHASES + 1, shadow.selector);
		if (shadow.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

>>> drrip_stream_aware_replacement.f
+incdir+rtl
rtl/drrip_pkg.sv
rtl/drrip_stream_aware_replacement.sv
rtl/drrip_chk.sv
verif/rrip_shadow_pkg.sv
verif/tb_top.sv
